// File: hdl/cnd_pkg.sv
// Package with shared types and constants of the cross-neighbor despeckle filter.
`timescale 1ns / 1ps

package cnd_pkg;

    localparam int CFG_ADDR_BITS = 2;
    localparam int CFG_DATA_BITS = 10;
    localparam int COLS_BITS     = 6;
    localparam int ROWS_BITS     = 10;
    localparam int THR_BITS      = 4;

    localparam logic [CFG_ADDR_BITS-1:0] REG_FRAME_COLS     = 2'd0;
    localparam logic [CFG_ADDR_BITS-1:0] REG_FRAME_ROWS     = 2'd1;
    localparam logic [CFG_ADDR_BITS-1:0] REG_DIFF_THRESHOLD = 2'd2;

    localparam logic [COLS_BITS-1:0] COLS_RESET = 6'd30;
    localparam logic [ROWS_BITS-1:0] ROWS_RESET = 10'd20;
    localparam logic [THR_BITS-1:0]  THR_RESET  = 4'd1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FADDR,
        ST_READ,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic up;
        logic left;
        logic right;
        logic down;
    } nb_mask_t;

endpackage

// File: hdl/cnd_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
`timescale 1ns / 1ps

module cnd_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: hdl/cnd_core.sv
// Despeckle arithmetic: neighbor test against the threshold and rounded average.
`timescale 1ns / 1ps

module cnd_core #(
    parameter int PIXEL_BITS = 4
) (
    input  logic [PIXEL_BITS-1:0]          center,
    input  logic [PIXEL_BITS-1:0]          up,
    input  logic [PIXEL_BITS-1:0]          left,
    input  logic [PIXEL_BITS-1:0]          right,
    input  logic [PIXEL_BITS-1:0]          down,
    input  cnd_pkg::nb_mask_t              mask,
    input  logic [cnd_pkg::THR_BITS-1:0]   thr,
    output logic [PIXEL_BITS-1:0]          result
);

    localparam int CW = PIXEL_BITS + 1;
    localparam int SW = PIXEL_BITS + 2;
    localparam int K  = SW + 1;
    localparam int PW = SW + K;
    localparam logic [K-1:0] RECIP = K'(((1 << K) + 2) / 3);

    logic [CW-1:0] center_w;
    logic [CW-1:0] thr_w;
    logic          ex_up;
    logic          ex_left;
    logic          ex_right;
    logic          ex_down;
    logic          all_exceed;
    logic [2:0]    cnt;
    logic [SW-1:0] sum;
    logic [SW-1:0] sum_inc;
    logic [PW-1:0] prod;
    logic [SW-1:0] avg;

    assign center_w = {1'b0, center};
    assign thr_w    = CW'(thr);

    assign ex_up    = center_w > ({1'b0, up} + thr_w);
    assign ex_left  = center_w > ({1'b0, left} + thr_w);
    assign ex_right = center_w > ({1'b0, right} + thr_w);
    assign ex_down  = center_w > ({1'b0, down} + thr_w);

    assign all_exceed = (!mask.up || ex_up) && (!mask.left || ex_left)
                     && (!mask.right || ex_right) && (!mask.down || ex_down);

    assign cnt = 3'(mask.up) + 3'(mask.left) + 3'(mask.right) + 3'(mask.down);

    assign sum = (mask.up    ? SW'(up)    : '0)
               + (mask.left  ? SW'(left)  : '0)
               + (mask.right ? SW'(right) : '0)
               + (mask.down  ? SW'(down)  : '0);

    // A third of sum + 1 gives the half-up rounding for three neighbors.
    assign sum_inc = sum + SW'(1);
    assign prod    = PW'(sum_inc) * PW'(RECIP);

    always_comb
    begin
        case (cnt)
            3'd1:    avg = sum;
            3'd2:    avg = (sum + SW'(1)) >> 1;
            3'd3:    avg = prod[K +: SW];
            3'd4:    avg = (sum + SW'(2)) >> 2;
            default: avg = SW'(center);
        endcase
    end

    assign result = (cnt == 3'd0 || !all_exceed) ? center : avg[PIXEL_BITS-1:0];

endmodule

// File: hdl/cross_neighbor_despeckle_filter.sv
// Top level of the cross-neighbor despeckle filter: sequencer, row stores and output register.
//
//  Channel | Direction | Handshake              | Payload
//  s_*     | in        | s_tvalid / s_tready    | s_tdata: pixel_in
//  m_*     | out       | m_tvalid / m_tready    | m_tdata: pixel_out, m_tlast: frame_end
//  cfg_*   | in        | cfg_we (no wait)       | cfg_addr, cfg_wdata
//
// First-row pixels are only stored; other pixels pass the read and result states, because the
// single read port of the raw row store delivers the center and the right neighbor in turn.
// The last pixel of a frame is followed by a flush of the last row, read out column by column.
// The row stores are not cleared at reset; entries are written before they are read.
// While the output register holds an untaken transfer, the block waits with the next result.
`timescale 1ns / 1ps

module cross_neighbor_despeckle_filter #(
    parameter int MAX_COLS   = 32,
    parameter int PIXEL_BITS = 4
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [((PIXEL_BITS+7)/8)*8-1:0]     s_tdata,   // pixel_in
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [((PIXEL_BITS+7)/8)*8-1:0]     m_tdata,   // pixel_out
    output logic                                m_tlast,
    input  logic                                cfg_we,
    input  logic [cnd_pkg::CFG_ADDR_BITS-1:0]   cfg_addr,
    input  logic [cnd_pkg::CFG_DATA_BITS-1:0]   cfg_wdata
);

    localparam int DW = ((PIXEL_BITS + 7) / 8) * 8;
    localparam int AW = $clog2(MAX_COLS);
    localparam int NB = cnd_pkg::COLS_BITS;
    localparam int RB = cnd_pkg::ROWS_BITS;

    cnd_pkg::state_t             state_reg, state_next;
    logic [NB-1:0]               cols_cfg_reg;
    logic [RB-1:0]               rows_cfg_reg;
    logic [cnd_pkg::THR_BITS-1:0] thr_cfg_reg;

    logic [AW-1:0]               col_reg, col_next;
    logic [RB-1:0]               row_reg, row_next;
    logic [AW-1:0]               idx_reg, idx_next;
    logic                        up_ok_reg, up_ok_next;
    logic                        flush_reg, flush_next;
    logic [PIXEL_BITS-1:0]       pix_reg, pix_next;
    logic [PIXEL_BITS-1:0]       center_reg, center_next;
    logic [PIXEL_BITS-1:0]       up_reg, up_next;
    logic [PIXEL_BITS-1:0]       left_reg, left_next;
    logic                        out_valid_reg, out_valid_next;
    logic [PIXEL_BITS-1:0]       out_pix_reg, out_pix_next;
    logic                        out_last_reg, out_last_next;

    logic [NB-1:0]               eff_cols;
    logic [RB-1:0]               eff_rows;
    logic                        col_last;
    logic                        idx_last;
    logic                        row_last;
    logic [AW-1:0]               idx_inc;
    logic                        out_free;
    logic                        accept;

    logic                        raw_we, raw_re;
    logic [AW-1:0]               raw_waddr, raw_raddr;
    logic [PIXEL_BITS-1:0]       raw_wdata, raw_rdata;
    logic                        filt_we, filt_re;
    logic [AW-1:0]               filt_raddr;
    logic [PIXEL_BITS-1:0]       filt_rdata;

    cnd_pkg::nb_mask_t           mask;
    logic [PIXEL_BITS-1:0]       core_v;

    assign eff_cols = (cols_cfg_reg == '0) ? NB'(1)
                    : ((cols_cfg_reg > NB'(MAX_COLS)) ? NB'(MAX_COLS) : cols_cfg_reg);
    assign eff_rows = (rows_cfg_reg == '0) ? RB'(1) : rows_cfg_reg;

    assign col_last = (NB'(col_reg) + NB'(1)) >= eff_cols;
    assign idx_last = (NB'(idx_reg) + NB'(1)) >= eff_cols;
    assign row_last = ((RB + 1)'(row_reg) + (RB + 1)'(1)) >= (RB + 1)'(eff_rows);
    assign idx_inc  = idx_reg + AW'(1);
    assign out_free = !out_valid_reg || m_tready;

    assign s_tready = (state_reg == cnd_pkg::ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = DW'(out_pix_reg);
    assign m_tlast  = out_last_reg;

    assign mask.up    = up_ok_reg;
    assign mask.left  = (idx_reg != '0);
    assign mask.right = !idx_last;
    assign mask.down  = !flush_reg;

    cnd_ram #(
        .WIDTH (PIXEL_BITS),
        .DEPTH (MAX_COLS)
    ) u_raw_ram (
        .clk   (clk),
        .we    (raw_we),
        .waddr (raw_waddr),
        .wdata (raw_wdata),
        .re    (raw_re),
        .raddr (raw_raddr),
        .rdata (raw_rdata)
    );

    cnd_ram #(
        .WIDTH (PIXEL_BITS),
        .DEPTH (MAX_COLS)
    ) u_filt_ram (
        .clk   (clk),
        .we    (filt_we),
        .waddr (idx_reg),
        .wdata (core_v),
        .re    (filt_re),
        .raddr (filt_raddr),
        .rdata (filt_rdata)
    );

    cnd_core #(
        .PIXEL_BITS (PIXEL_BITS)
    ) u_core (
        .center (center_reg),
        .up     (up_reg),
        .left   (left_reg),
        .right  (raw_rdata),
        .down   (pix_reg),
        .mask   (mask),
        .thr    (thr_cfg_reg),
        .result (core_v)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cols_cfg_reg <= cnd_pkg::COLS_RESET;
            rows_cfg_reg <= cnd_pkg::ROWS_RESET;
            thr_cfg_reg  <= cnd_pkg::THR_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                cnd_pkg::REG_FRAME_COLS:     cols_cfg_reg <= cfg_wdata[NB-1:0];
                cnd_pkg::REG_FRAME_ROWS:     rows_cfg_reg <= cfg_wdata[RB-1:0];
                cnd_pkg::REG_DIFF_THRESHOLD: thr_cfg_reg  <= cfg_wdata[cnd_pkg::THR_BITS-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= cnd_pkg::ST_IDLE;
            col_reg       <= '0;
            row_reg       <= '0;
            idx_reg       <= '0;
            up_ok_reg     <= 1'b0;
            flush_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            left_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            idx_reg       <= idx_next;
            up_ok_reg     <= up_ok_next;
            flush_reg     <= flush_next;
            out_valid_reg <= out_valid_next;
            left_reg      <= left_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pix_reg      <= pix_next;
        center_reg   <= center_next;
        up_reg       <= up_next;
        out_pix_reg  <= out_pix_next;
        out_last_reg <= out_last_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        idx_next       = idx_reg;
        up_ok_next     = up_ok_reg;
        flush_next     = flush_reg;
        pix_next       = pix_reg;
        center_next    = center_reg;
        up_next        = up_reg;
        left_next      = left_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_pix_next   = out_pix_reg;
        out_last_next  = out_last_reg;
        raw_we         = 1'b0;
        raw_waddr      = idx_reg;
        raw_wdata      = pix_reg;
        raw_re         = 1'b0;
        raw_raddr      = idx_reg;
        filt_we        = 1'b0;
        filt_re        = 1'b0;
        filt_raddr     = idx_reg;

        unique case (state_reg)
            cnd_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    pix_next = s_tdata[PIXEL_BITS-1:0];
                    idx_next = col_reg;
                    if (row_reg == '0)
                    begin
                        raw_we    = 1'b1;
                        raw_waddr = col_reg;
                        raw_wdata = s_tdata[PIXEL_BITS-1:0];
                        if (col_last)
                        begin
                            col_next = '0;
                            if (row_last)
                            begin
                                row_next   = '0;
                                flush_next = 1'b1;
                                up_ok_next = 1'b0;
                                idx_next   = '0;
                                state_next = cnd_pkg::ST_FADDR;
                            end
                            else
                            begin
                                row_next = row_reg + RB'(1);
                            end
                        end
                        else
                        begin
                            col_next = col_reg + AW'(1);
                        end
                    end
                    else
                    begin
                        raw_re     = 1'b1;
                        filt_re    = 1'b1;
                        raw_raddr  = col_reg;
                        filt_raddr = col_reg;
                        up_ok_next = (row_reg >= RB'(2));
                        flush_next = 1'b0;
                        state_next = cnd_pkg::ST_READ;
                    end
                end
            end

            cnd_pkg::ST_FADDR:
            begin
                raw_re     = 1'b1;
                filt_re    = 1'b1;
                state_next = cnd_pkg::ST_READ;
            end

            cnd_pkg::ST_READ:
            begin
                center_next = raw_rdata;
                up_next     = filt_rdata;
                raw_re      = 1'b1;
                raw_raddr   = idx_inc;
                state_next  = cnd_pkg::ST_EMIT;
            end

            cnd_pkg::ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_pix_next   = core_v;
                    filt_we        = 1'b1;
                    left_next      = core_v;
                    if (!flush_reg)
                    begin
                        raw_we        = 1'b1;
                        out_last_next = 1'b0;
                        state_next    = cnd_pkg::ST_IDLE;
                        if (idx_last)
                        begin
                            col_next = '0;
                            if (row_last)
                            begin
                                row_next   = '0;
                                flush_next = 1'b1;
                                up_ok_next = 1'b1;
                                idx_next   = '0;
                                state_next = cnd_pkg::ST_FADDR;
                            end
                            else
                            begin
                                row_next = row_reg + RB'(1);
                            end
                        end
                        else
                        begin
                            col_next = col_reg + AW'(1);
                        end
                    end
                    else
                    begin
                        out_last_next = idx_last;
                        if (idx_last)
                        begin
                            flush_next = 1'b0;
                            state_next = cnd_pkg::ST_IDLE;
                        end
                        else
                        begin
                            idx_next   = idx_inc;
                            raw_re     = 1'b1;
                            filt_re    = 1'b1;
                            raw_raddr  = idx_inc;
                            filt_raddr = idx_inc;
                            state_next = cnd_pkg::ST_READ;
                        end
                    end
                end
            end

            default:
            begin
                state_next = cnd_pkg::ST_IDLE;
            end
        endcase
    end

    a_emit_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == cnd_pkg::ST_EMIT && !out_free) |=> (state_reg == cnd_pkg::ST_EMIT))
        else $error("Result stage left while the output register was still occupied.");

    a_no_accept_in_flush: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> !flush_reg)
        else $error("Input transfer taken while the last row was being flushed.");

    a_read_then_emit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == cnd_pkg::ST_READ) |=> (state_reg == cnd_pkg::ST_EMIT))
        else $error("Read stage was not followed by the result stage.");

    a_filt_write_with_output: assert property (@(posedge clk) disable iff (!rst_n)
        filt_we |=> out_valid_reg)
        else $error("Filtered row store written without a result being presented.");

endmodule
